FILE: rtl/core/vn_pkg.sv
// Shared types for the three-axis vector normalizer.
package vn_pkg;

  // Control bits that travel with one lane's item through the root search.
  typedef struct packed {
    logic vld;
    logic neg;
  } lane_ctl_t;

endpackage

FILE: rtl/core/vn_step.sv
// One restoring step of the unit-magnitude bit search for a single lane.
module vn_step #(
  parameter int SW  = 16,
  parameter int F   = 14,
  parameter int BIT = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  vn_pkg::lane_ctl_t       ctl_in,
  input  logic [2*SW-1:0]         s_in,
  input  logic [2*SW+2*F-1:0]     r_in,
  input  logic [2*SW+F:0]         p_in,
  input  logic [F:0]              q_in,
  output vn_pkg::lane_ctl_t       ctl_out,
  output logic [2*SW-1:0]         s_out,
  output logic [2*SW+2*F-1:0]     r_out,
  output logic [2*SW+F:0]         p_out,
  output logic [F:0]              q_out
);
  import vn_pkg::*;

  localparam int TW = 2*SW + 2*F;
  localparam int PW = 2*SW + F + 1;
  localparam int DW = TW + 4;

  lane_ctl_t       ctl_r;
  logic [2*SW-1:0] s_r;
  logic [TW-1:0]   r_r;
  logic [PW-1:0]   p_r;
  logic [F:0]      q_r;

  logic [DW-1:0]   delta;
  logic            take;
  logic [TW-1:0]   r_nxt;
  logic [PW-1:0]   p_nxt;
  logic [F:0]      q_nxt;

  // Setting this bit of q grows q^2*S by 2*q*S*2^BIT + S*4^BIT.
  always_comb begin
    delta = (DW'(p_in) << (BIT + 1)) + (DW'(s_in) << (2 * BIT));
    take  = DW'(r_in) >= delta;
    r_nxt = take ? (r_in - delta[TW-1:0]) : r_in;
    p_nxt = take ? (p_in + (PW'(s_in) << BIT)) : p_in;
    q_nxt = q_in;
    if (take) begin
      q_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_in;
      r_r <= r_nxt;
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign s_out   = s_r;
  assign r_out   = r_r;
  assign p_out   = p_r;
  assign q_out   = q_r;

endmodule

FILE: rtl/core/vn_lane.sv
// One component lane: a pipelined bit search for floor(a * 2^F / sqrt(S)).
module vn_lane #(
  parameter int SW = 16,
  parameter int F  = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  vn_pkg::lane_ctl_t     ctl_in,
  input  logic [2*SW-1:0]       s_in,
  input  logic [2*SW+2*F-1:0]   t_in,
  output vn_pkg::lane_ctl_t     ctl_out,
  output logic [F:0]            q_out
);
  import vn_pkg::*;

  localparam int TW = 2*SW + 2*F;
  localparam int PW = 2*SW + F + 1;

  lane_ctl_t       ctl_w [F+2];
  logic [2*SW-1:0] s_w   [F+2];
  logic [TW-1:0]   r_w   [F+2];
  logic [PW-1:0]   p_w   [F+2];
  logic [F:0]      q_w   [F+2];

  assign ctl_w[0] = ctl_in;
  assign s_w[0]   = s_in;
  assign r_w[0]   = t_in;
  assign p_w[0]   = '0;
  assign q_w[0]   = '0;

  // The most significant bit is decided first; q = 2^F is the largest answer.
  for (genvar k = 0; k <= F; k++) begin : g_step
    vn_step #(.SW(SW), .F(F), .BIT(F - k)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl_w[k]),
      .s_in    (s_w[k]),
      .r_in    (r_w[k]),
      .p_in    (p_w[k]),
      .q_in    (q_w[k]),
      .ctl_out (ctl_w[k+1]),
      .s_out   (s_w[k+1]),
      .r_out   (r_w[k+1]),
      .p_out   (p_w[k+1]),
      .q_out   (q_w[k+1])
    );
  end

  assign ctl_out = ctl_w[F+1];
  assign q_out   = q_w[F+1];

endmodule

FILE: rtl/core/vector3_normalizer.sv
// Top level of the three-axis vector normalizer: unit vector in signed Q1.F.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_ready  | in_x_in, in_y_in, in_z_in
//   result   | out_valid / out_ready| out_x_unit, out_y_unit, out_z_unit,
//            |                      | out_zero_vector
//
// One item is taken per cycle unless the pipeline is frozen. The stages are: one
// capture stage, one multiply stage, one sum stage, one restoring stage per
// result bit in each of the three lanes, and the output register.
// Reset (rst_n, synchronous, active low) clears all valid bits.
// The whole pipeline advances together; it freezes only while the output
// register holds an item that has not been taken.
module vector3_normalizer #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_z_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_FRAC_BITS+1:0] out_x_unit,
  output logic signed [OUT_FRAC_BITS+1:0] out_y_unit,
  output logic signed [OUT_FRAC_BITS+1:0] out_z_unit,
  output logic                          out_zero_vector
);
  import vn_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = OUT_FRAC_BITS;
  localparam int OW = F + 2;
  localparam int TW = 2*SW + 2*F;

  logic en;

  // Capture stage: sign and magnitude of each axis.
  logic          a_vld_r;
  logic [SW-1:0] a_mag_r [3];
  logic [2:0]    a_neg_r;

  // Multiply stage: squares.
  logic            b_vld_r;
  logic [2*SW-1:0] b_sq_r [3];
  logic [2:0]      b_neg_r;

  // Sum stage: the lanes are joined into one sum of squares.
  logic            c_vld_r;
  logic [2*SW-1:0] c_s_r;
  logic [2*SW-1:0] c_sq_r [3];
  logic [2:0]      c_neg_r;
  logic            c_zero_r;

  logic [F:0]      zero_dly_r;
  lane_ctl_t       lane_ctl [3];
  logic [F:0]      lane_q   [3];

  logic          o_vld_r;
  logic [OW-1:0] o_unit_r [3];
  logic          o_zero_r;

  logic signed [SW-1:0] in_axis [3];

  assign in_axis[0] = in_x_in;
  assign in_axis[1] = in_y_in;
  assign in_axis[2] = in_z_in;

  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      o_vld_r    <= 1'b0;
    end else if (en) begin
      a_vld_r    <= in_valid;
      b_vld_r    <= a_vld_r;
      c_vld_r    <= b_vld_r;
      o_vld_r    <= lane_ctl[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_r[i] <= in_axis[i][SW-1];
        a_mag_r[i] <= in_axis[i][SW-1] ? (SW'(0) - in_axis[i]) : in_axis[i];
        b_sq_r[i]  <= (2*SW)'(a_mag_r[i]) * (2*SW)'(a_mag_r[i]);
        c_sq_r[i]  <= b_sq_r[i];
      end
      b_neg_r  <= a_neg_r;
      c_neg_r  <= b_neg_r;
      c_s_r    <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_zero_r <= (b_sq_r[0] == '0) && (b_sq_r[1] == '0) && (b_sq_r[2] == '0);
      zero_dly_r <= {zero_dly_r[F-1:0], c_zero_r};
    end
  end

  // Three lanes search each component against the shared sum of squares.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    lane_ctl_t ctl_in;
    assign ctl_in.vld = c_vld_r;
    assign ctl_in.neg = c_neg_r[i];

    vn_lane #(.SW(SW), .F(F)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl_in),
      .s_in    (c_s_r),
      .t_in    (TW'(c_sq_r[i]) << (2 * F)),
      .ctl_out (lane_ctl[i]),
      .q_out   (lane_q[i])
    );
  end

  // Output register: apply signs, force zeros for a zero vector.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_dly_r[F]) begin
          o_unit_r[i] <= '0;
        end else if (lane_ctl[i].neg) begin
          o_unit_r[i] <= OW'(0) - OW'(lane_q[i]);
        end else begin
          o_unit_r[i] <= OW'(lane_q[i]);
        end
      end
      o_zero_r <= zero_dly_r[F];
    end
  end

  assign out_valid       = o_vld_r;
  assign out_x_unit      = o_unit_r[0];
  assign out_y_unit      = o_unit_r[1];
  assign out_z_unit      = o_unit_r[2];
  assign out_zero_vector = o_zero_r;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the three-axis vector normalizer.
module tb_top;

  localparam int SW = 16;
  localparam int FB = 14;
  localparam int OW = FB + 2;
  localparam int LATENCY = FB + 5;
  localparam int RANDOM_ITEMS = 950;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_x_in, in_y_in, in_z_in;
  logic out_valid;
  logic out_ready;
  logic signed [OW-1:0] out_x_unit, out_y_unit, out_z_unit;
  logic out_zero_vector;

  // One normalized result, as the block should deliver it.
  typedef struct packed {
    logic [OW-1:0] ux;
    logic [OW-1:0] uy;
    logic [OW-1:0] uz;
    logic          zero;
  } unit_vec_t;

  // One row of the directed table: a sample, and optionally a known answer.
  typedef struct {
    logic [SW-1:0] x;
    logic [SW-1:0] y;
    logic [SW-1:0] z;
    bit            known;
    unit_vec_t     answer;
  } sample_row_t;

  unit_vec_t pending_units[$];
  int        error_count;
  int        idle_cycles;
  bit        timed_out;
  bit        stimulus_done;

  localparam logic [OW-1:0] ONE = OW'(1) << FB;
  localparam logic [OW-1:0] MINUS_ONE = -(OW'(1) << FB);

  vector3_normalizer #(.SAMPLE_WIDTH(SW), .OUT_FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_in(in_x_in), .in_y_in(in_y_in), .in_z_in(in_z_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x_unit(out_x_unit), .out_y_unit(out_y_unit), .out_z_unit(out_z_unit),
    .out_zero_vector(out_zero_vector)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Largest q in [0, 2^FB] whose square times the sum of squares does not
  // exceed a^2 * 2^(2*FB). This is the quotient rounded toward zero, found
  // without ever rounding a square root. 128-bit products leave ample room.
  function automatic logic [OW-1:0] scaled_ratio(input logic [63:0] a,
                                                 input logic [63:0] sumsq);
    logic [127:0] target;
    logic [63:0]  lo, hi, mid;
    target = (128'(a) * 128'(a)) << (2 * FB);
    lo = 0;
    hi = 64'(1) << FB;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (128'(mid) * 128'(mid) * 128'(sumsq) <= target) lo = mid;
      else hi = mid - 1;
    end
    return lo[OW-1:0];
  endfunction

  // Expected unit vector of one raw sample. Magnitudes are rounded first and
  // the sign is applied afterwards, so negative results round toward zero.
  function automatic unit_vec_t normalize(input logic [SW-1:0] x,
                                          input logic [SW-1:0] y,
                                          input logic [SW-1:0] z);
    logic [SW-1:0] raw[3];
    logic [63:0]   mag[3];
    logic [63:0]   sumsq;
    logic [OW-1:0] q[3];
    unit_vec_t     r;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw[i][SW-1] ? 64'((~raw[i] + 1'b1) & {SW{1'b1}}) : 64'(raw[i]);
      if (raw[i][SW-1] && raw[i] == {1'b1, {(SW-1){1'b0}}}) mag[i] = 64'(1) << (SW-1);
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zero: 1'b1};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q[i] = scaled_ratio(mag[i], sumsq);
      if (raw[i][SW-1]) q[i] = -q[i];
    end
    r = '{ux: q[0], uy: q[1], uz: q[2], zero: 1'b0};
    return r;
  endfunction

  // Random axis value, biased toward the extremes, small values and zero.
  function automatic logic [SW-1:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return {1'b0, {(SW-1){1'b1}}};
      3: return SW'($urandom_range(0, 8)) - SW'(4);
      default: return SW'($urandom);
    endcase
  endfunction

  // Most gaps are short, with an occasional long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until the block accepts it.
  task automatic send_sample(input logic [SW-1:0] x, input logic [SW-1:0] y,
                             input logic [SW-1:0] z);
    in_x_in  <= x;
    in_y_in  <= y;
    in_z_in  <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Every item accepted at this edge gets its expectation queued here, so the
  // queue always leads the result channel.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_units.push_back(normalize(in_x_in, in_y_in, in_z_in));
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    unit_vec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d zero=%0b",
                 $time, out_x_unit, out_y_unit, out_z_unit, out_zero_vector);
        error_count++;
      end else begin
        want = pending_units.pop_front();
        if (out_x_unit !== want.ux) begin
          $display("%0t: x_unit expected %0d, got %0d", $time,
                   $signed(want.ux), out_x_unit);
          error_count++;
        end
        if (out_y_unit !== want.uy) begin
          $display("%0t: y_unit expected %0d, got %0d", $time,
                   $signed(want.uy), out_y_unit);
          error_count++;
        end
        if (out_z_unit !== want.uz) begin
          $display("%0t: z_unit expected %0d, got %0d", $time,
                   $signed(want.uz), out_z_unit);
          error_count++;
        end
        if (out_zero_vector !== want.zero) begin
          $display("%0t: zero_vector expected %0b, got %0b", $time,
                   want.zero, out_zero_vector);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls at random, with stretches of steady readiness.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!stimulus_done || pending_units.size() != 0) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
      out_ready <= (stall == 0);
      repeat (stall == 0 ? $urandom_range(1, 30) : stall) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (stimulus_done && pending_units.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("vector3_normalizer verification failed");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    unit_vec_t   got;
    logic [SW-1:0] max_pos, max_neg;
    max_pos = {1'b0, {(SW-1){1'b1}}};
    max_neg = {1'b1, {(SW-1){1'b0}}};
    error_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_in = '0;
    in_y_in = '0;
    in_z_in = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: the zero vector, single-axis extremes, and mixes that
    // exercise rounding toward zero on negative components.
    rows.push_back('{'0, '0, '0, 1'b1, '{'0, '0, '0, 1'b1}});
    rows.push_back('{max_pos, '0, '0, 1'b1, '{ONE, '0, '0, 1'b0}});
    rows.push_back('{max_neg, '0, '0, 1'b1, '{MINUS_ONE, '0, '0, 1'b0}});
    rows.push_back('{'0, max_pos, '0, 1'b1, '{'0, ONE, '0, 1'b0}});
    rows.push_back('{'0, max_neg, '0, 1'b1, '{'0, MINUS_ONE, '0, 1'b0}});
    rows.push_back('{'0, '0, max_pos, 1'b1, '{'0, '0, ONE, 1'b0}});
    rows.push_back('{'0, '0, max_neg, 1'b1, '{'0, '0, MINUS_ONE, 1'b0}});
    rows.push_back('{SW'(1), '0, '0, 1'b1, '{ONE, '0, '0, 1'b0}});
    rows.push_back('{'0, '0, {SW{1'b1}}, 1'b1, '{'0, '0, MINUS_ONE, 1'b0}});
    rows.push_back('{max_pos, max_pos, max_pos, 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{max_neg, max_neg, max_neg, 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{max_neg, max_pos, max_neg, 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{SW'(1), SW'(1), SW'(1), 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{{SW{1'b1}}, SW'(1), {SW{1'b1}}, 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{SW'(3), SW'(4), '0, 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{-SW'(3), '0, -SW'(4), 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{SW'(1), max_neg, SW'(2), 1'b0, '{'0, '0, '0, 1'b0}});
    rows.push_back('{SW'(16'h5555), SW'(16'hAAAA), SW'(16'h0F0F), 1'b0,
                     '{'0, '0, '0, 1'b0}});

    foreach (rows[i]) begin
      // Hand-typed answers are checked against the predictor first;
      // the predictor then checks the block itself.
      if (rows[i].known) begin
        got = normalize(rows[i].x, rows[i].y, rows[i].z);
        if (got !== rows[i].answer) begin
          $display("%0t: row %0d expected %h, predictor gives %h", $time, i,
                   rows[i].answer, got);
          error_count++;
        end
      end
      send_sample(rows[i].x, rows[i].y, rows[i].z);
      pause_sender(($urandom_range(0, 2) == 0) ? gap_length() : 0);
    end

    // Let the pipeline drain completely once before the random part.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_units.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_sample(pick_axis(), pick_axis(), pick_axis());
      if (n % 200 < 60)
        pause_sender(0);
      else
        pause_sender(($urandom_range(0, 1) == 0) ? gap_length() : 0);
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_units.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;

    while (pending_units.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (error_count == 0 && pending_units.size() == 0)
      $display("vector3_normalizer verification clean");
    else
      $display("vector3_normalizer verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/vn_pkg.sv
rtl/core/vn_step.sv
rtl/core/vn_lane.sv
rtl/core/vector3_normalizer.sv
verif/tb_top.sv
